// ===== rtl/rlbp_pkg.sv =====
// shared types and constants of the resistor ladder button poller
package rlbp_pkg;

  localparam int unsigned BUTTON_COUNT         = 7;
  localparam int unsigned FIRST_LADDER_BUTTONS = 4;
  localparam int unsigned SAMPLE_BITS          = 10;

  localparam int unsigned IDX_W      = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned BUTTON_W   = 3;
  localparam int unsigned LADDER_A_W = 40;
  localparam int unsigned LADDER_B_W = 30;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [LADDER_A_W-1:0]  LADDER_A_RESET  = 40'd367756225447;
  localparam logic [LADDER_B_W-1:0]  LADDER_B_RESET  = 30'd360365993;
  localparam logic [SAMPLE_BITS-1:0] TOLERANCE_RESET = SAMPLE_BITS'(10);
  localparam logic [MS_W-1:0]        SHORT_MS_RESET  = 16'd300;
  localparam logic [MS_W-1:0]        LONG_MS_RESET   = 16'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LADDER_A  = 3'd0,
    CFG_LADDER_B  = 3'd1,
    CFG_TOLERANCE = 3'd2,
    CFG_SHORT_MS  = 3'd3,
    CFG_LONG_MS   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef enum logic {
    KIND_SHORT = 1'b0,
    KIND_LONG  = 1'b1
  } press_kind_e;

  // per button entry as stored in the state memory
  typedef struct packed {
    logic               pressed;
    logic [TIME_W-1:0]  ptime;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // one press event on its way to the output
  typedef struct packed {
    logic [BUTTON_W-1:0] button;
    press_kind_e         kind;
    logic [COUNT_W-1:0]  count;
  } event_t;

endpackage

// ===== rtl/rlbp_ram.sv =====
// generic single write port ram with registered read
module rlbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/resistor_ladder_button_poller.sv =====
// top level of the resistor ladder button poller
//
// each accepted poll item (time stamp plus one adc sample per ladder) walks all
// buttons once through a small state memory holding pressed flag, press time
// and burst count per button; a button is pressed when its sample lies strictly
// within match_tolerance of its threshold. a poll reads the first entry when it
// is accepted, does one read-modify-write per button with the next entry read in
// the same cycle, and then hands over the final event. the walk pauses when a new
// event needs the slot while the output register and the one-event holding slot
// are both full, so a slow consumer stretches a poll. events (short or long
// press) leave in button order
// and the final event of a poll carries last_event. the memory needs no clearing
// pass: a valid bit per entry makes unwritten entries read as released with zero
// time and count. configuration writes take effect at once and are meant to be
// done while no poll is in flight.
module resistor_ladder_button_poller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // poll items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rlbp_pkg::TIME_W-1:0]          now_ms_i,
  input  logic [rlbp_pkg::SAMPLE_BITS-1:0]     ladder_a_sample_i,
  input  logic [rlbp_pkg::SAMPLE_BITS-1:0]     ladder_b_sample_i,
  // press events
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [rlbp_pkg::BUTTON_W-1:0]        button_index_o,
  output logic                                 press_kind_o,
  output logic [rlbp_pkg::COUNT_W-1:0]         press_count_o,
  output logic                                 last_event_o,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [rlbp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rlbp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int unsigned EXT_A_W = rlbp_pkg::LADDER_A_W
                                  + rlbp_pkg::BUTTON_COUNT * rlbp_pkg::SAMPLE_BITS;
  localparam int unsigned EXT_B_W = rlbp_pkg::LADDER_B_W
                                  + rlbp_pkg::BUTTON_COUNT * rlbp_pkg::SAMPLE_BITS;
  localparam int unsigned ENTRY_W = $bits(rlbp_pkg::entry_t);
  localparam logic [rlbp_pkg::IDX_W-1:0] LAST_IDX =
    rlbp_pkg::IDX_W'(rlbp_pkg::BUTTON_COUNT - 1);

  // configuration registers
  logic [rlbp_pkg::LADDER_A_W-1:0]  ladder_a_q;
  logic [rlbp_pkg::LADDER_B_W-1:0]  ladder_b_q;
  logic [rlbp_pkg::SAMPLE_BITS-1:0] tolerance_q;
  logic [rlbp_pkg::MS_W-1:0]        short_ms_q;
  logic [rlbp_pkg::MS_W-1:0]        long_ms_q;

  // poll being worked on
  rlbp_pkg::state_e                 state_q, state_d;
  logic [rlbp_pkg::IDX_W-1:0]       idx_q;
  logic [rlbp_pkg::TIME_W-1:0]      now_q;
  logic [rlbp_pkg::SAMPLE_BITS-1:0] sample_a_q, sample_b_q;

  // entry valid bits stand in for the memory reset
  logic [rlbp_pkg::BUTTON_COUNT-1:0] vld_q;

  // holding slot and output register
  logic                             pend_q;
  rlbp_pkg::event_t                 pend_ev_q;
  logic                             out_vld_q;
  rlbp_pkg::event_t                 out_ev_q;
  logic                             out_last_q;

  // memory signals
  logic                             ram_we, ram_re;
  logic [rlbp_pkg::IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]               ram_rdata;
  rlbp_pkg::entry_t                 entry_rd, entry_wr;

  // per button datapath
  logic [rlbp_pkg::SAMPLE_BITS-1:0] thr [rlbp_pkg::BUTTON_COUNT];
  logic [rlbp_pkg::SAMPLE_BITS-1:0] cur_thr, cur_sample, diff;
  logic                             now_pressed;
  logic [rlbp_pkg::TIME_W-1:0]      elapsed;
  logic                             ev_fire;
  rlbp_pkg::event_t                 ev_new;
  logic                             out_free, stall, advance, accept;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_vld_q || out_ready_i;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ladder_a_q  <= rlbp_pkg::LADDER_A_RESET;
      ladder_b_q  <= rlbp_pkg::LADDER_B_RESET;
      tolerance_q <= rlbp_pkg::TOLERANCE_RESET;
      short_ms_q  <= rlbp_pkg::SHORT_MS_RESET;
      long_ms_q   <= rlbp_pkg::LONG_MS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rlbp_pkg::CFG_LADDER_A:  ladder_a_q  <= cfg_wdata_i[rlbp_pkg::LADDER_A_W-1:0];
        rlbp_pkg::CFG_LADDER_B:  ladder_b_q  <= cfg_wdata_i[rlbp_pkg::LADDER_B_W-1:0];
        rlbp_pkg::CFG_TOLERANCE: tolerance_q <= cfg_wdata_i[rlbp_pkg::SAMPLE_BITS-1:0];
        rlbp_pkg::CFG_SHORT_MS:  short_ms_q  <= cfg_wdata_i[rlbp_pkg::MS_W-1:0];
        rlbp_pkg::CFG_LONG_MS:   long_ms_q   <= cfg_wdata_i[rlbp_pkg::MS_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // thresholds per button; fields past the end of a register read as zero
  always_comb begin
    logic [EXT_A_W-1:0] ext_a;
    logic [EXT_B_W-1:0] ext_b;
    int unsigned        slot;
    ext_a = EXT_A_W'(ladder_a_q);
    ext_b = EXT_B_W'(ladder_b_q);
    for (int unsigned b = 0; b < rlbp_pkg::BUTTON_COUNT; b++) begin
      if (b < rlbp_pkg::FIRST_LADDER_BUTTONS) begin
        slot   = b;
        thr[b] = ext_a[slot*rlbp_pkg::SAMPLE_BITS +: rlbp_pkg::SAMPLE_BITS];
      end else begin
        slot   = b - rlbp_pkg::FIRST_LADDER_BUTTONS;
        thr[b] = ext_b[slot*rlbp_pkg::SAMPLE_BITS +: rlbp_pkg::SAMPLE_BITS];
      end
    end
  end

  // state memory, one entry per button
  rlbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (rlbp_pkg::BUTTON_COUNT)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (entry_wr),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entry never written reads as released, zero time, zero count
  assign entry_rd = vld_q[idx_q] ? rlbp_pkg::entry_t'(ram_rdata) : '0;

  // match test and per button update
  always_comb begin
    cur_thr     = thr[idx_q];
    cur_sample  = ({1'b0, idx_q} < (rlbp_pkg::IDX_W+1)'(rlbp_pkg::FIRST_LADDER_BUTTONS))
                  ? sample_a_q : sample_b_q;
    diff        = (cur_sample >= cur_thr) ? (cur_sample - cur_thr) : (cur_thr - cur_sample);
    now_pressed = diff < tolerance_q;
    elapsed     = now_q - entry_rd.ptime;

    entry_wr         = entry_rd;
    entry_wr.pressed = now_pressed;
    ev_fire          = 1'b0;
    ev_new.button    = rlbp_pkg::BUTTON_W'(idx_q);
    ev_new.kind      = rlbp_pkg::KIND_SHORT;
    ev_new.count     = entry_rd.count;

    if (now_pressed && !entry_rd.pressed) begin
      // new press opens or extends a burst
      entry_wr.ptime = now_q;
      entry_wr.count = entry_rd.count + rlbp_pkg::COUNT_W'(1);
    end else if (!now_pressed && !entry_rd.pressed) begin
      // quiet long enough: burst ends, short press only if not too late
      if (elapsed > rlbp_pkg::TIME_W'(short_ms_q) && entry_rd.count != '0) begin
        ev_fire        = elapsed < rlbp_pkg::TIME_W'(long_ms_q);
        entry_wr.count = '0;
      end
    end else if (now_pressed && entry_rd.pressed) begin
      // single press held past the long time
      if (elapsed > rlbp_pkg::TIME_W'(long_ms_q) && entry_rd.count == rlbp_pkg::COUNT_W'(1))
      begin
        ev_fire        = 1'b1;
        ev_new.kind    = rlbp_pkg::KIND_LONG;
        ev_new.count   = rlbp_pkg::COUNT_W'(1);
        entry_wr.count = rlbp_pkg::COUNT_W'(2);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlbp_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = rlbp_pkg::ST_SCAN;
        end
      end
      rlbp_pkg::ST_SCAN: begin
        if (advance && idx_q == LAST_IDX) begin
          state_d = rlbp_pkg::ST_FLUSH;
        end
      end
      rlbp_pkg::ST_FLUSH: begin
        if (!pend_q || out_free) begin
          state_d = rlbp_pkg::ST_IDLE;
        end
      end
      default: state_d = rlbp_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    stall      = 1'b0;
    advance    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    unique case (state_q)
      rlbp_pkg::ST_IDLE: begin
        // ready is high here, so a valid poll is taken at this edge
        in_ready_o = 1'b1;
        ram_re     = in_valid_i;
      end
      rlbp_pkg::ST_SCAN: begin
        // a new event needs the slot, which must first drain into the output
        stall     = ev_fire && pend_q && !out_free;
        advance   = !stall;
        ram_we    = advance;
        ram_re    = advance && idx_q != LAST_IDX;
        ram_raddr = idx_q + rlbp_pkg::IDX_W'(1);
      end
      rlbp_pkg::ST_FLUSH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rlbp_pkg::ST_IDLE;
      idx_q     <= '0;
      vld_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (accept) begin
        idx_q <= '0;
      end else if (advance && idx_q != LAST_IDX) begin
        idx_q <= idx_q + rlbp_pkg::IDX_W'(1);
      end

      if (ram_we) begin
        vld_q[idx_q] <= 1'b1;
      end

      // held event moves into the output register, else a taken item empties it
      if ((advance && ev_fire && pend_q)
          || (state_q == rlbp_pkg::ST_FLUSH && pend_q && out_free)) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end

      if (advance && ev_fire) begin
        pend_q <= 1'b1;
      end else if (state_q == rlbp_pkg::ST_FLUSH && pend_q && out_free) begin
        pend_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q      <= now_ms_i;
      sample_a_q <= ladder_a_sample_i;
      sample_b_q <= ladder_b_sample_i;
    end
    if (advance && ev_fire) begin
      pend_ev_q <= ev_new;
      if (pend_q) begin
        out_ev_q   <= pend_ev_q;
        out_last_q <= 1'b0;
      end
    end else if (state_q == rlbp_pkg::ST_FLUSH && pend_q && out_free) begin
      out_ev_q   <= pend_ev_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign button_index_o = out_ev_q.button;
  assign press_kind_o   = out_ev_q.kind;
  assign press_count_o  = out_ev_q.count;
  assign last_event_o   = out_last_q;

`ifndef SYNTHESIS
  // no event may be held over once the poll is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rlbp_pkg::ST_IDLE |-> !pend_q)
    else $error("event left in holding slot while idle");

  // a stalled scan keeps its place in the button walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rlbp_pkg::ST_SCAN && stall) |=> state_q == rlbp_pkg::ST_SCAN && $stable(idx_q))
    else $error("scan moved on during a stall");

  // an accepted poll starts its walk at the first button
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == rlbp_pkg::ST_SCAN && idx_q == '0)
    else $error("poll did not start at the first button");

  // the final hand over only follows a complete walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rlbp_pkg::ST_FLUSH |-> idx_q == LAST_IDX)
    else $error("flush reached before the last button");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the resistor ladder button poller against a press predictor
module tb_top;
  import rlbp_pkg::*;

  localparam int unsigned CLK_PERIOD      = 8;
  localparam int unsigned RESET_CYCLES    = 11;
  // one poll reads the first entry, walks every button entry and hands over the final event
  localparam int unsigned POLL_CYCLES     = BUTTON_COUNT + 2;
  localparam int unsigned SETTLE_CYCLES   = 4 * POLL_CYCLES;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned HOLD_OFF_AFTER  = 120;
  // longest quiet stretch of a correct run is the hold-off plus a few stalls
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int          SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
  // first register index that maps to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = 3'd5;

  typedef struct packed {
    logic [BUTTON_W-1:0] button;
    press_kind_e         kind;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } press_evt_t;

  // press predictor plus the queue of press events still owed by the block
  class button_press_scoreboard;
    logic [LADDER_A_W-1:0]  thr_a;
    logic [LADDER_B_W-1:0]  thr_b;
    logic [SAMPLE_BITS-1:0] tol;
    logic [MS_W-1:0]        short_ms;
    logic [MS_W-1:0]        long_ms;
    bit                     held[BUTTON_COUNT];
    logic [TIME_W-1:0]      pressed_at[BUTTON_COUNT];
    logic [COUNT_W-1:0]     presses[BUTTON_COUNT];
    press_evt_t             owed_presses[$];
    int                     polls;
    int                     shorts;
    int                     longs;
    int                     mismatches;

    function new();
      thr_a    = LADDER_A_RESET;
      thr_b    = LADDER_B_RESET;
      tol      = TOLERANCE_RESET;
      short_ms = SHORT_MS_RESET;
      long_ms  = LONG_MS_RESET;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        held[b]       = 1'b0;
        pressed_at[b] = '0;
        presses[b]    = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LADDER_A:  thr_a = data[LADDER_A_W-1:0];
        CFG_LADDER_B:  thr_b = data[LADDER_B_W-1:0];
        CFG_TOLERANCE: tol = data[SAMPLE_BITS-1:0];
        CFG_SHORT_MS:  short_ms = data[MS_W-1:0];
        CFG_LONG_MS:   long_ms = data[MS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [SAMPLE_BITS-1:0] threshold(int b);
      if (b < FIRST_LADDER_BUTTONS) return thr_a[b*SAMPLE_BITS +: SAMPLE_BITS];
      return thr_b[(b-FIRST_LADDER_BUTTONS)*SAMPLE_BITS +: SAMPLE_BITS];
    endfunction

    // walk all buttons for one accepted poll and queue the events it causes
    function void note_poll(logic [TIME_W-1:0] now, logic [SAMPLE_BITS-1:0] sample_a,
                            logic [SAMPLE_BITS-1:0] sample_b);
      logic [SAMPLE_BITS-1:0] sample;
      logic [SAMPLE_BITS-1:0] thr;
      logic [SAMPLE_BITS-1:0] diff;
      logic [TIME_W-1:0]      elapsed;
      bit                     hit;
      press_evt_t             evt;
      int                     owed_before;
      owed_before = owed_presses.size();
      polls++;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        sample  = (b < FIRST_LADDER_BUTTONS) ? sample_a : sample_b;
        thr     = threshold(b);
        diff    = (sample >= thr) ? sample - thr : thr - sample;
        hit     = diff < tol;
        elapsed = now - pressed_at[b];
        evt.button = BUTTON_W'(b);
        evt.count  = presses[b];
        evt.last   = 1'b0;
        if (hit && !held[b]) begin
          pressed_at[b] = now;
          presses[b]++;
        end else if (!hit && !held[b]) begin
          if (elapsed > short_ms && presses[b] != '0) begin
            if (elapsed < long_ms) begin
              evt.kind = KIND_SHORT;
              owed_presses.push_back(evt);
            end
            presses[b] = '0;
          end
        end else if (hit && held[b] && elapsed > long_ms && presses[b] == 1) begin
          evt.kind = KIND_LONG;
          owed_presses.push_back(evt);
          presses[b] = 2;
        end
        held[b] = hit;
      end
      if (owed_presses.size() > owed_before) begin
        evt      = owed_presses.pop_back();
        evt.last = 1'b1;
        owed_presses.push_back(evt);
      end
    endfunction

    function void compare_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_event(press_evt_t got);
      press_evt_t want;
      if (owed_presses.size() == 0) begin
        mismatches++;
        $display("%0t: event with none expected, button %0d kind %0d count %0d", $time,
                 got.button, got.kind, got.count);
        return;
      end
      want = owed_presses.pop_front();
      if (want.kind == KIND_LONG) longs++;
      else shorts++;
      compare_field("button_index", COUNT_W'(want.button), COUNT_W'(got.button));
      compare_field("press_kind", COUNT_W'(want.kind), COUNT_W'(got.kind));
      compare_field("press_count", want.count, got.count);
      compare_field("last_event", COUNT_W'(want.last), COUNT_W'(got.last));
    endfunction

    function int pending();
      return owed_presses.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [TIME_W-1:0]      now_ms_i;
  logic [SAMPLE_BITS-1:0] ladder_a_sample_i;
  logic [SAMPLE_BITS-1:0] ladder_b_sample_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [BUTTON_W-1:0]    button_index_o;
  logic                   press_kind_o;
  logic [COUNT_W-1:0]     press_count_o;
  logic                   last_event_o;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  button_press_scoreboard press_board;
  logic [TIME_W-1:0]      poll_ms;     // time stamp of the next poll
  int                     target_a;    // button the first ladder is parked on, -1 for none
  int                     target_b;
  bit                     burst_mode;  // both sides run without idling
  bit                     hold_done;
  int                     cfg_writes;

  resistor_ladder_button_poller i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .now_ms_i          (now_ms_i),
    .ladder_a_sample_i (ladder_a_sample_i),
    .ladder_b_sample_i (ladder_b_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .button_index_o    (button_index_o),
    .press_kind_o      (press_kind_o),
    .press_count_o     (press_count_o),
    .last_event_o      (last_event_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one, none at all in burst mode
  function automatic int idle_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sample close to a threshold; edge_pct of them sit exactly at the tolerance, which misses
  function automatic logic [SAMPLE_BITS-1:0] near_sample(logic [SAMPLE_BITS-1:0] thr,
                                                         int edge_pct);
    int tol;
    int off;
    int v;
    tol = press_board.tol;
    if (tol == 0) off = $urandom_range(0, 3);
    else if ($urandom_range(0, 99) < edge_pct) off = tol;
    else off = $urandom_range(0, tol - 1);
    v = $urandom_range(0, 1) ? int'(thr) + off : int'(thr) - off;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_BITS'(v);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] ladder_sample(int target);
    if (target < 0) return SAMPLE_BITS'($urandom);
    return near_sample(press_board.threshold(target), 10);
  endfunction

  // mostly poll-sized steps, some long quiet spells, rarely a jump anywhere
  function automatic void advance_clock(int step_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) poll_ms = $urandom;
    else if (r < 10) poll_ms += $urandom_range(0, step_max * 8);
    else poll_ms += $urandom_range(0, step_max);
  endfunction

  // offer one poll item and hold it until the block takes it
  task automatic send_poll(logic [TIME_W-1:0] now, logic [SAMPLE_BITS-1:0] sample_a,
                           logic [SAMPLE_BITS-1:0] sample_b);
    int gap;
    gap = idle_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    now_ms_i          = now;
    ladder_a_sample_i = sample_a;
    ladder_b_sample_i = sample_b;
    do @(posedge clk_i); while (!in_ready_o);
    press_board.note_poll(now, sample_a, sample_b);
    if ($urandom_range(0, 99) < 3) burst_mode = !burst_mode;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    press_board.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_timing(int tol, int short_ms, int long_ms);
    write_register(CFG_TOLERANCE, CFG_DATA_W'(tol));
    write_register(CFG_SHORT_MS, CFG_DATA_W'(short_ms));
    write_register(CFG_LONG_MS, CFG_DATA_W'(long_ms));
  endtask

  // drop valid, wait for every owed event, then let a poll with no events finish its walk
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (press_board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // each ladder stays parked on a button or off the ladder for a few polls, so presses
  // are held, released and repeated with random samples around the thresholds
  task automatic run_random(int n, int step_max, int change_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < change_pct)
        target_a = $urandom_range(0, 1) ? -1 : $urandom_range(0, FIRST_LADDER_BUTTONS - 1);
      if ($urandom_range(0, 99) < change_pct)
        target_b = $urandom_range(0, 1) ? -1 :
                   $urandom_range(FIRST_LADDER_BUTTONS, BUTTON_COUNT - 1);
      advance_clock(step_max);
      send_poll(poll_ms, ladder_sample(target_a), ladder_sample(target_b));
    end
  endtask

  // event sink with random stalls and one long hold-off that backs the block up
  initial begin : event_sink
    int         stall_left;
    press_evt_t got;
    stall_left  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && press_board.polls >= HOLD_OFF_AFTER) begin
        out_ready_i = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        stall_left  = idle_gap();
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.button = button_index_o;
        got.kind   = press_kind_e'(press_kind_o);
        got.count  = press_count_o;
        got.last   = last_event_o;
        press_board.check_event(got);
      end
    end
  end

  // ends a hung run: too long without any item moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int k;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    now_ms_i          = '0;
    ladder_a_sample_i = '0;
    ladder_b_sample_i = '0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = '0;
    cfg_wdata_i       = '0;
    press_board       = new();
    target_a          = -1;
    target_b          = -1;
    burst_mode        = 1'b0;
    hold_done         = 1'b0;
    cfg_writes        = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed polls on reset settings: exact thresholds, press then short press report
    send_poll(32'd1000, 10'd935, 10'd937);
    send_poll(32'd1100, 10'd100, 10'd100);
    send_poll(32'd1400, 10'd100, 10'd100);
    // tolerance edges: nine steps off still matches, ten steps off does not
    send_poll(32'd1450, 10'd944, 10'd946);
    send_poll(32'd1460, 10'd945, 10'd947);
    send_poll(32'd1470, 10'd926, 10'd928);
    send_poll(32'd1480, 10'd925, 10'd927);
    send_poll(32'd1900, 10'd0, 10'd0);
    // hold past the long time, then a release that ends the burst without a report
    send_poll(32'd2000, 10'd682, 10'd687);
    send_poll(32'd3000, 10'd682, 10'd687);
    send_poll(32'd5001, 10'd682, 10'd687);
    send_poll(32'd5100, 10'd1023, 10'd1023);
    send_poll(32'd5500, 10'd1023, 10'd1023);
    // bursts that straddle the wrap of the millisecond counter
    send_poll(32'hFFFF_FF00, 10'd511, 10'd343);
    send_poll(32'hFFFF_FF10, 10'd342, 10'd343);
    send_poll(32'h0000_0100, 10'd0, 10'd1023);
    // press and release at the same time stamp: no quiet time, no report
    send_poll(32'h0000_0100, 10'd511, 10'd0);
    send_poll(32'h0000_0100, 10'd0, 10'd0);
    send_poll(32'hFFFF_FFFF, 10'd0, 10'd0);
    send_poll(32'h0000_0000, 10'd0, 10'd0);

    // reset settings, polls about every 60 ms
    poll_ms = 32'd10000;
    run_random(80, 120, 35);

    // random thresholds with tight timing, plus a write to an unmapped index
    settle();
    write_register(CFG_LADDER_A, CFG_DATA_W'({$urandom, $urandom}));
    write_register(CFG_LADDER_B, CFG_DATA_W'($urandom));
    write_register(CFG_FIRST_SPARE + CFG_IDX_W'($urandom_range(0, 2)),
                   CFG_DATA_W'({$urandom, $urandom}));
    set_timing($urandom_range(1, 40), 100, 400);
    run_random(130, 150, 35);

    // extreme thresholds, widest tolerance, zero short and long times
    settle();
    write_register(CFG_LADDER_A, CFG_DATA_W'({10'd1023, 10'd0, 10'd1023, 10'd0}));
    write_register(CFG_LADDER_B, CFG_DATA_W'({10'd0, 10'd1023, 10'd512}));
    set_timing(SAMPLE_MAX, 0, 0);
    run_random(50, 20, 50);

    // zero tolerance: nothing matches, open bursts only drain
    settle();
    set_timing(0, 1000, 16'hFFFF);
    run_random(50, 3000, 35);

    // random thresholds with the time stamp running over its wrap
    settle();
    write_register(CFG_LADDER_A, CFG_DATA_W'({$urandom, $urandom}));
    write_register(CFG_LADDER_B, CFG_DATA_W'($urandom));
    write_register(CFG_FIRST_SPARE + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
    set_timing($urandom_range(1, 40), 50, 300);
    poll_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    run_random(120, 60, 35);

    // long burst: press and release buttons 0 and 4 many times with no quiet time reached
    settle();
    write_register(CFG_LADDER_A, CFG_DATA_W'(LADDER_A_RESET));
    write_register(CFG_LADDER_B, CFG_DATA_W'(LADDER_B_RESET));
    set_timing(10, 16'hFFFF, 16'hFFFF);
    k = $urandom_range(0, 3);
    for (int j = 0; j < 2 * (12 + k); j++) begin
      poll_ms += $urandom_range(0, 20);
      if (j % 2 == 0)
        send_poll(poll_ms, near_sample(press_board.threshold(0), 0),
                  near_sample(press_board.threshold(FIRST_LADDER_BUTTONS), 0));
      else
        send_poll(poll_ms, SAMPLE_BITS'($urandom_range(0, 300)),
                  SAMPLE_BITS'($urandom_range(0, 300)));
    end

    // short quiet time so the open bursts get reported with their counts
    settle();
    set_timing(10, 10, 16'hFFFF);
    repeat (8) begin
      poll_ms += 30;
      send_poll(poll_ms, SAMPLE_BITS'($urandom_range(0, 300)),
                SAMPLE_BITS'($urandom_range(0, 300)));
    end

    settle();
    $display("ran %0d polls, checked %0d short and %0d long press events, %0d register writes",
             press_board.polls, press_board.shorts, press_board.longs, cfg_writes);
    $display("covered reset settings, tight timing, extreme thresholds, zero tolerance, %s",
             "time wrap, long press bursts and a long output stall");
    if (press_board.mismatches == 0 && press_board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
